/* hdl/tft_pkg.sv */
`timescale 1ns / 1ps

package tft_pkg;

  localparam int COORD_WIDTH = 20;
  localparam int UNIT_WIDTH  = 16;

  // edge width after the subtract; wide coordinates lose their low bits
  localparam int EDGE_W     = COORD_WIDTH + 1;
  localparam int EDGE_SHIFT = (COORD_WIDTH > 30) ? COORD_WIDTH - 30 : 0;

  // width of the vectors fed to the normalizer
  localparam int VW     = 64;
  localparam int ONE_SH = UNIT_WIDTH - 2;
  localparam int ONE    = 1 << ONE_SH;
  localparam int NUDGE  = (ONE + 50) / 100;

  localparam int SQRT_STEPS = 32;
  localparam int QUO_BITS   = UNIT_WIDTH - 1;
  localparam int NORM_LAT   = 8 + SQRT_STEPS + QUO_BITS;
  localparam int TOTAL_LAT  = 13 + 4 * NORM_LAT;

  typedef logic [2:0][VW-1:0]         wvec_t;
  typedef logic [2:0][UNIT_WIDTH-1:0] uvec_t;
  typedef logic [2:0][EDGE_W-1:0]     evec_t;

  function automatic logic [COORD_WIDTH-1:0] take_coord(logic [63:0] word, int idx);
    logic [63:0] sh;
    sh = (idx * COORD_WIDTH >= 64) ? '0 : word >> (idx * COORD_WIDTH);
    return sh[COORD_WIDTH-1:0];
  endfunction

  function automatic logic [UNIT_WIDTH-1:0] take_unit(logic [63:0] word, int idx);
    logic [63:0] sh;
    sh = (idx * UNIT_WIDTH >= 64) ? '0 : word >> (idx * UNIT_WIDTH);
    return sh[UNIT_WIDTH-1:0];
  endfunction

  // p1 - p0, magnitude truncated by EDGE_SHIFT
  function automatic logic [EDGE_W-1:0] coord_delta(logic [COORD_WIDTH-1:0] p1,
                                                    logic [COORD_WIDTH-1:0] p0);
    logic signed [EDGE_W-1:0] df;
    logic [EDGE_W-1:0] m;
    df = EDGE_W'($signed(p1)) - EDGE_W'($signed(p0));
    m  = df[EDGE_W-1] ? EDGE_W'(-df) : EDGE_W'(df);
    m  = m >> EDGE_SHIFT;
    return df[EDGE_W-1] ? -m : m;
  endfunction

endpackage

/* hdl/tft_norm.sv */
`timescale 1ns / 1ps

module tft_norm import tft_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  wvec_t in_vec,
  output logic  out_valid,
  output uvec_t out_vec
);

  localparam int NGRP = VW / 8;

  // stage 1: magnitudes
  logic        s1_v;
  logic [2:0]  s1_neg;
  wvec_t       s1_mag;
  logic [VW-1:0] s1_or;

  // stage 2: per-byte leading one
  logic        s2_v;
  logic [2:0]  s2_neg;
  wvec_t       s2_mag;
  logic [NGRP-1:0]      s2_nz;
  logic [NGRP-1:0][2:0] s2_lp;
  logic [NGRP-1:0][2:0] lp_c;

  // stage 3: leading one position
  logic        s3_v;
  logic [2:0]  s3_neg;
  wvec_t       s3_mag;
  logic [5:0]  s3_pos;
  logic        s3_zero;
  logic [5:0]  pos_c;

  // stage 4: scaled magnitudes
  logic        s4_v;
  logic [2:0]  s4_neg;
  logic        s4_zero;
  logic [2:0][30:0] s4_m;

  // stage 5: squares
  logic        s5_v;
  logic [2:0]  s5_neg;
  logic        s5_zero;
  logic [2:0][30:0] s5_m;
  logic [2:0][61:0] s5_sq;

  // square root steps
  logic [VW-1:0]    sq_n    [SQRT_STEPS+1];
  logic [VW-1:0]    sq_r    [SQRT_STEPS+1];
  logic [2:0][30:0] sq_m    [SQRT_STEPS+1];
  logic [2:0]       sq_neg  [SQRT_STEPS+1];
  logic             sq_zero [SQRT_STEPS+1];
  logic             sq_v    [SQRT_STEPS+1];

  // divider steps
  wvec_t                    dv_rem  [QUO_BITS+1];
  logic [VW-1:0]            dv_den  [QUO_BITS+1];
  logic [2:0][QUO_BITS-1:0] dv_q    [QUO_BITS+1];
  logic [2:0]               dv_neg  [QUO_BITS+1];
  logic                     dv_zero [QUO_BITS+1];
  logic                     dv_v    [QUO_BITS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
      s5_v <= 1'b0;
      sq_v[0] <= 1'b0;
    end else begin
      s1_v <= in_valid;
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= s3_v;
      s5_v <= s4_v;
      sq_v[0] <= s5_v;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s1_neg[i] <= in_vec[i][VW-1];
      s1_mag[i] <= in_vec[i][VW-1] ? -in_vec[i] : in_vec[i];
    end
    s1_or <= (in_vec[0][VW-1] ? -in_vec[0] : in_vec[0]) |
             (in_vec[1][VW-1] ? -in_vec[1] : in_vec[1]) |
             (in_vec[2][VW-1] ? -in_vec[2] : in_vec[2]);
  end

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      lp_c[g] = '0;
      for (int b = 0; b < 8; b++) begin
        if (s1_or[g*8 + b]) lp_c[g] = 3'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    s2_neg <= s1_neg;
    s2_mag <= s1_mag;
    s2_lp  <= lp_c;
    for (int g = 0; g < NGRP; g++) begin
      s2_nz[g] <= |s1_or[g*8 +: 8];
    end
  end

  always_comb begin
    pos_c = '0;
    for (int g = 0; g < NGRP; g++) begin
      if (s2_nz[g]) pos_c = 6'(g * 8) + 6'(s2_lp[g]);
    end
  end

  always_ff @(posedge clk) begin
    s3_neg  <= s2_neg;
    s3_mag  <= s2_mag;
    s3_zero <= ~|s2_nz;
    s3_pos  <= pos_c;
  end

  // bring the largest magnitude into [2^30, 2^31)
  always_ff @(posedge clk) begin
    s4_neg  <= s3_neg;
    s4_zero <= s3_zero;
    for (int i = 0; i < 3; i++) begin
      if (s3_pos > 6'd30) s4_m[i] <= 31'(s3_mag[i] >> (s3_pos - 6'd30));
      else                s4_m[i] <= 31'(s3_mag[i] << (6'd30 - s3_pos));
    end
  end

  always_ff @(posedge clk) begin
    s5_neg  <= s4_neg;
    s5_zero <= s4_zero;
    s5_m    <= s4_m;
    for (int i = 0; i < 3; i++) begin
      s5_sq[i] <= s4_m[i] * s4_m[i];
    end
  end

  always_ff @(posedge clk) begin
    sq_n[0]    <= VW'(s5_sq[0]) + VW'(s5_sq[1]) + VW'(s5_sq[2]);
    sq_r[0]    <= '0;
    sq_m[0]    <= s5_m;
    sq_neg[0]  <= s5_neg;
    sq_zero[0] <= s5_zero;
  end

  // one result bit per stage
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [VW-1:0] BITV = VW'(1) << (62 - 2 * k);
    logic [VW-1:0] trial;
    assign trial = sq_r[k] + BITV;

    always_ff @(posedge clk) begin
      if (rst) sq_v[k+1] <= 1'b0;
      else     sq_v[k+1] <= sq_v[k];
    end

    always_ff @(posedge clk) begin
      if (sq_n[k] >= trial) begin
        sq_n[k+1] <= sq_n[k] - trial;
        sq_r[k+1] <= (sq_r[k] >> 1) + BITV;
      end else begin
        sq_n[k+1] <= sq_n[k];
        sq_r[k+1] <= sq_r[k] >> 1;
      end
      sq_m[k+1]    <= sq_m[k];
      sq_neg[k+1]  <= sq_neg[k];
      sq_zero[k+1] <= sq_zero[k];
    end
  end

  // quotient = (2*m*ONE + L) / (2*L)
  always_ff @(posedge clk) begin
    if (rst) dv_v[0] <= 1'b0;
    else     dv_v[0] <= sq_v[SQRT_STEPS];
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      dv_rem[0][i] <= (VW'(sq_m[SQRT_STEPS][i]) << (ONE_SH + 1)) + sq_r[SQRT_STEPS];
    end
    dv_den[0]  <= sq_r[SQRT_STEPS] << 1;
    dv_q[0]    <= '0;
    dv_neg[0]  <= sq_neg[SQRT_STEPS];
    dv_zero[0] <= sq_zero[SQRT_STEPS];
  end

  for (genvar j = 0; j < QUO_BITS; j++) begin : g_div
    localparam int BP = QUO_BITS - 1 - j;
    logic [VW-1:0] dsh;
    logic [2:0]    hit;
    assign dsh = dv_den[j] << BP;

    always_comb begin
      for (int i = 0; i < 3; i++) hit[i] = (dv_rem[j][i] >= dsh);
    end

    always_ff @(posedge clk) begin
      if (rst) dv_v[j+1] <= 1'b0;
      else     dv_v[j+1] <= dv_v[j];
    end

    always_ff @(posedge clk) begin
      for (int i = 0; i < 3; i++) begin
        dv_rem[j+1][i] <= hit[i] ? dv_rem[j][i] - dsh : dv_rem[j][i];
        dv_q[j+1][i]   <= dv_q[j][i] | (QUO_BITS'(hit[i]) << BP);
      end
      dv_den[j+1]  <= dv_den[j];
      dv_neg[j+1]  <= dv_neg[j];
      dv_zero[j+1] <= dv_zero[j];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else     out_valid <= dv_v[QUO_BITS];
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (dv_zero[QUO_BITS])       out_vec[i] <= '0;
      else if (dv_neg[QUO_BITS][i]) out_vec[i] <= -UNIT_WIDTH'(dv_q[QUO_BITS][i]);
      else                          out_vec[i] <= UNIT_WIDTH'(dv_q[QUO_BITS][i]);
    end
  end

endmodule

/* hdl/triangle_tangent_frame_top.sv */
`timescale 1ns / 1ps
// Throughput: one triangle per clock; busy never rises.
// Depth comes from four normalizers, each a 32-step square root and a 15-step divider.
// Results cannot be stalled: done is a one-cycle strobe.
// Reset (rst, synchronous) clears all valid bits; data registers are not reset.

module triangle_tangent_frame_top import tft_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [59:0] corner_a_pos,
  input  logic [59:0] corner_b_pos,
  input  logic [59:0] corner_c_pos,
  input  logic [31:0] corner_a_uv,
  input  logic [31:0] corner_b_uv,
  input  logic [31:0] corner_c_uv,
  input  logic [47:0] stored_normal,
  output logic        done,
  output logic [47:0] tangent_vec,
  output logic [47:0] binormal_vec,
  output logic [47:0] normal_vec,
  output logic        uv_degenerate,
  output logic        face_degenerate
);

  localparam int UW   = UNIT_WIDTH;
  localparam int DUW  = UW + 1;
  localparam int FPW  = 2 * EDGE_W;
  localparam int UVPW = 2 * DUW;
  localparam int CPW  = DUW + EDGE_W;
  localparam int DOTW = 2 * UW + 2;
  localparam int DW   = UW + 4;
  localparam int NDW  = UW + DW;

  typedef struct packed {
    uvec_t sn;
    wvec_t t;
    logic  fd;
    logic  ud;
  } side1_t;

  typedef struct packed {
    uvec_t n;
    logic  fd;
    logic  ud;
  } side2_t;

  typedef struct packed {
    uvec_t tf;
    uvec_t n;
    logic  fd;
    logic  ud;
  } side4_t;

  assign busy = 1'b0;

  // ---------------- stage A: unpack, edges, UV deltas
  logic  a_v;
  evec_t a_e0, a_e1;
  uvec_t a_sn;
  logic signed [DUW-1:0] a_du0, a_du1, a_dv0, a_dv1;

  always_ff @(posedge clk) begin
    if (rst) a_v <= 1'b0;
    else     a_v <= start & ~busy;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      a_e0[i] <= coord_delta(take_coord(64'(corner_b_pos), i),
                             take_coord(64'(corner_a_pos), i));
      a_e1[i] <= coord_delta(take_coord(64'(corner_c_pos), i),
                             take_coord(64'(corner_a_pos), i));
      a_sn[i] <= take_unit(64'(stored_normal), i);
    end
    a_du0 <= DUW'($signed(take_unit(64'(corner_b_uv), 0))) -
             DUW'($signed(take_unit(64'(corner_a_uv), 0)));
    a_du1 <= DUW'($signed(take_unit(64'(corner_c_uv), 0))) -
             DUW'($signed(take_unit(64'(corner_a_uv), 0)));
    a_dv0 <= DUW'($signed(take_unit(64'(corner_b_uv), 1))) -
             DUW'($signed(take_unit(64'(corner_a_uv), 1)));
    a_dv1 <= DUW'($signed(take_unit(64'(corner_c_uv), 1))) -
             DUW'($signed(take_unit(64'(corner_a_uv), 1)));
  end

  // ---------------- stage B: products
  logic b_v;
  logic signed [FPW-1:0]  b_fa [3];
  logic signed [FPW-1:0]  b_fb [3];
  logic signed [UVPW-1:0] b_d1, b_d2;
  logic signed [CPW-1:0]  b_c1 [3];
  logic signed [CPW-1:0]  b_c2 [3];
  uvec_t b_sn;
  logic signed [EDGE_W-1:0] e0s [3];
  logic signed [EDGE_W-1:0] e1s [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e0s[i] = $signed(a_e0[i]);
      e1s[i] = $signed(a_e1[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) b_v <= 1'b0;
    else     b_v <= a_v;
  end

  always_ff @(posedge clk) begin
    b_fa[0] <= e0s[1] * e1s[2];
    b_fb[0] <= e0s[2] * e1s[1];
    b_fa[1] <= e0s[2] * e1s[0];
    b_fb[1] <= e0s[0] * e1s[2];
    b_fa[2] <= e0s[0] * e1s[1];
    b_fb[2] <= e0s[1] * e1s[0];
    b_d1    <= a_du0 * a_dv1;
    b_d2    <= a_dv0 * a_du1;
    for (int i = 0; i < 3; i++) begin
      b_c1[i] <= a_dv1 * e0s[i];
      b_c2[i] <= a_dv0 * e1s[i];
    end
    b_sn <= a_sn;
  end

  // ---------------- stage C: differences
  logic  c_v;
  wvec_t c_fc, c_c;
  logic signed [UVPW:0] c_det;
  uvec_t c_sn;

  always_ff @(posedge clk) begin
    if (rst) c_v <= 1'b0;
    else     c_v <= b_v;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      c_fc[i] <= VW'(b_fa[i]) - VW'(b_fb[i]);
      c_c[i]  <= VW'(b_c1[i]) - VW'(b_c2[i]);
    end
    c_det <= (UVPW+1)'(b_d1) - (UVPW+1)'(b_d2);
    c_sn  <= b_sn;
  end

  // ---------------- stage D: flags, tangent sign
  logic  d_v, d_fd, d_ud;
  wvec_t d_fc, d_t;
  uvec_t d_sn;

  always_ff @(posedge clk) begin
    if (rst) d_v <= 1'b0;
    else     d_v <= c_v;
  end

  always_ff @(posedge clk) begin
    d_fd <= (c_fc == '0);
    d_ud <= (c_det == '0);
    d_fc <= c_fc;
    d_sn <= c_sn;
    for (int i = 0; i < 3; i++) begin
      d_t[i] <= c_det[UVPW] ? -c_c[i] : c_c[i];
    end
  end

  // ---------------- face normal
  logic  n1_v;
  uvec_t n1_vec;
  side1_t s1_dly [NORM_LAT];

  tft_norm u_norm_face (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d_v),
    .in_vec    (d_fc),
    .out_valid (n1_v),
    .out_vec   (n1_vec)
  );

  always_ff @(posedge clk) begin
    s1_dly[0].sn <= d_sn;
    s1_dly[0].t  <= d_t;
    s1_dly[0].fd <= d_fd;
    s1_dly[0].ud <= d_ud;
    for (int k = 1; k < NORM_LAT; k++) s1_dly[k] <= s1_dly[k-1];
  end

  // ---------------- stage E: pick normal and raw tangent
  logic  e_v, e_fd, e_ud;
  uvec_t e_n;
  wvec_t e_t;
  uvec_t n_sel;
  side1_t s1o;

  assign s1o   = s1_dly[NORM_LAT-1];
  assign n_sel = s1o.fd ? s1o.sn : n1_vec;

  always_ff @(posedge clk) begin
    if (rst) e_v <= 1'b0;
    else     e_v <= n1_v;
  end

  always_ff @(posedge clk) begin
    e_n  <= n_sel;
    e_fd <= s1o.fd;
    e_ud <= s1o.ud;
    if (s1o.ud) begin
      e_t[0] <= VW'($signed(n_sel[0])) + VW'(NUDGE);
      e_t[1] <= VW'($signed(n_sel[1]));
      e_t[2] <= VW'($signed(n_sel[2]));
    end else begin
      e_t <= s1o.t;
    end
  end

  // ---------------- first tangent normalize
  logic  n2_v;
  uvec_t n2_vec;
  side2_t s2_dly [NORM_LAT];
  side2_t s2o;

  tft_norm u_norm_tan (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (e_v),
    .in_vec    (e_t),
    .out_valid (n2_v),
    .out_vec   (n2_vec)
  );

  always_ff @(posedge clk) begin
    s2_dly[0].n  <= e_n;
    s2_dly[0].fd <= e_fd;
    s2_dly[0].ud <= e_ud;
    for (int k = 1; k < NORM_LAT; k++) s2_dly[k] <= s2_dly[k-1];
  end

  assign s2o = s2_dly[NORM_LAT-1];

  // ---------------- stages F..J: Gram-Schmidt
  logic f_v, g_v, h_v, i_v, j_v;
  logic signed [2*UW-1:0] f_pr [3];
  uvec_t f_tu, g_tu, h_tu;
  side2_t f_s, g_s, h_s, i_s, j_s;
  logic signed [DOTW-1:0] g_dot;
  logic [DOTW-1:0] dot_mag;
  logic [DOTW-1:0] dot_rnd;
  logic signed [DW-1:0] h_d;
  wvec_t i_a;
  logic signed [NDW-1:0] i_b [3];
  wvec_t j_w;

  assign dot_mag = g_dot[DOTW-1] ? DOTW'(-g_dot) : DOTW'(g_dot);
  assign dot_rnd = (dot_mag + DOTW'(ONE / 2)) >> ONE_SH;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_v <= 1'b0;
      g_v <= 1'b0;
      h_v <= 1'b0;
      i_v <= 1'b0;
      j_v <= 1'b0;
    end else begin
      f_v <= n2_v;
      g_v <= f_v;
      h_v <= g_v;
      i_v <= h_v;
      j_v <= i_v;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      f_pr[i] <= $signed(n2_vec[i]) * $signed(s2o.n[i]);
    end
    f_tu <= n2_vec;
    f_s  <= s2o;

    g_dot <= DOTW'(f_pr[0]) + DOTW'(f_pr[1]) + DOTW'(f_pr[2]);
    g_tu  <= f_tu;
    g_s   <= f_s;

    h_d  <= g_dot[DOTW-1] ? -DW'(dot_rnd) : DW'(dot_rnd);
    h_tu <= g_tu;
    h_s  <= g_s;

    for (int i = 0; i < 3; i++) begin
      i_a[i] <= VW'($signed(h_tu[i])) <<< ONE_SH;
      i_b[i] <= $signed(h_s.n[i]) * h_d;
    end
    i_s <= h_s;

    for (int i = 0; i < 3; i++) begin
      j_w[i] <= $signed(i_a[i]) - VW'(i_b[i]);
    end
    j_s <= i_s;
  end

  // ---------------- final tangent normalize
  logic  n3_v;
  uvec_t n3_vec;
  side2_t s3_dly [NORM_LAT];
  side2_t s3o;

  tft_norm u_norm_orth (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (j_v),
    .in_vec    (j_w),
    .out_valid (n3_v),
    .out_vec   (n3_vec)
  );

  always_ff @(posedge clk) begin
    s3_dly[0] <= j_s;
    for (int k = 1; k < NORM_LAT; k++) s3_dly[k] <= s3_dly[k-1];
  end

  assign s3o = s3_dly[NORM_LAT-1];

  // ---------------- stages K, L: binormal cross product
  logic k_v, l_v;
  logic signed [2*UW-1:0] k_pa [3];
  logic signed [2*UW-1:0] k_pb [3];
  uvec_t k_tf, l_tf;
  side2_t k_s, l_s;
  wvec_t l_bc;
  logic signed [UW-1:0] cn [3];
  logic signed [UW-1:0] ct [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cn[i] = $signed(s3o.n[i]);
      ct[i] = $signed(n3_vec[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k_v <= 1'b0;
      l_v <= 1'b0;
    end else begin
      k_v <= n3_v;
      l_v <= k_v;
    end
  end

  always_ff @(posedge clk) begin
    k_pa[0] <= cn[1] * ct[2];
    k_pb[0] <= cn[2] * ct[1];
    k_pa[1] <= cn[2] * ct[0];
    k_pb[1] <= cn[0] * ct[2];
    k_pa[2] <= cn[0] * ct[1];
    k_pb[2] <= cn[1] * ct[0];
    k_tf <= n3_vec;
    k_s  <= s3o;

    for (int i = 0; i < 3; i++) begin
      l_bc[i] <= VW'(k_pa[i]) - VW'(k_pb[i]);
    end
    l_tf <= k_tf;
    l_s  <= k_s;
  end

  // ---------------- binormal normalize and result register
  logic  n4_v;
  uvec_t n4_vec;
  side4_t s4_dly [NORM_LAT];
  side4_t s4o;

  tft_norm u_norm_bin (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (l_v),
    .in_vec    (l_bc),
    .out_valid (n4_v),
    .out_vec   (n4_vec)
  );

  always_ff @(posedge clk) begin
    s4_dly[0].tf <= l_tf;
    s4_dly[0].n  <= l_s.n;
    s4_dly[0].fd <= l_s.fd;
    s4_dly[0].ud <= l_s.ud;
    for (int k = 1; k < NORM_LAT; k++) s4_dly[k] <= s4_dly[k-1];
  end

  assign s4o = s4_dly[NORM_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= n4_v;
  end

  always_ff @(posedge clk) begin
    tangent_vec     <= 48'(s4o.tf);
    binormal_vec    <= 48'(n4_vec);
    normal_vec      <= 48'(s4o.n);
    uv_degenerate   <= s4o.ud;
    face_degenerate <= s4o.fd;
  end

endmodule

/* hdl/tft_checker.sv */
`timescale 1ns / 1ps

module tft_checker import tft_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [47:0] stored_normal,
  input logic        done,
  input logic [47:0] tangent_vec,
  input logic [47:0] normal_vec,
  input logic        face_degenerate
);

  // the pipeline never pushes back
  a_no_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy asserted");

  // every result traces back to a start transfer a fixed latency earlier
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, TOTAL_LAT))
    else $error("result without matching start transfer");

  // flat face: stored normal comes out unchanged
  a_face_fallback: assert property (@(posedge clk) disable iff (rst)
    done && face_degenerate |-> normal_vec == $past(stored_normal, TOTAL_LAT))
    else $error("fallback normal differs from stored normal");

  // tangent is unit length or zero, so no component exceeds one
  a_tan_range: assert property (@(posedge clk) disable iff (rst)
    done |-> ($signed(tangent_vec[UNIT_WIDTH-1:0]) <= ONE &&
              $signed(tangent_vec[UNIT_WIDTH-1:0]) >= -ONE &&
              $signed(tangent_vec[2*UNIT_WIDTH-1:UNIT_WIDTH]) <= ONE &&
              $signed(tangent_vec[2*UNIT_WIDTH-1:UNIT_WIDTH]) >= -ONE &&
              $signed(tangent_vec[3*UNIT_WIDTH-1:2*UNIT_WIDTH]) <= ONE &&
              $signed(tangent_vec[3*UNIT_WIDTH-1:2*UNIT_WIDTH]) >= -ONE))
    else $error("tangent component out of range");

endmodule

bind triangle_tangent_frame_top tft_checker u_tft_checker (.*);
